FILE: hdl/xyz2s_pkg.sv
package xyz2s_pkg;

   // fixed point layout
   localparam int ACC_FRAC = 28;
   localparam int SRGB_BITS = 16;
   localparam int SRGB_W = SRGB_BITS + 1;
   localparam int CHAN_W = 32;
   localparam int PROD_W = 34;
   localparam int SUM_W = 36;
   localparam int NUM_CHAN = 3;

   typedef logic signed [16:0] coef_type;
   typedef logic [SRGB_W-1:0] thresh_type;
   typedef thresh_type [255:0] srgb_tab_type;

   // control that travels with each pixel
   typedef struct packed {
      logic valid;
      logic scaled;
   } stage_ctl_type;

   // xyz to linear rgb, signed q2.14
   localparam coef_type MAT_COEF [0:2][0:2] = '{
      '{ 17'sd53092, -17'sd25184, -17'sd8168 },
      '{-17'sd15880,  17'sd30737,  17'sd681  },
      '{ 17'sd912,   -17'sd3343,   17'sd17322}
   };

   // does q0.16 value q reach gray level k
   function automatic logic srgb_meets(input int unsigned q, input int unsigned k);
      logic [263:0] lhs;
      logic [263:0] rhs;
      logic [63:0] n;
      if (k <= 10) begin
         return (64'(q) * 64'd16473) >= (64'd163840 * 64'(2 * k - 1));
      end
      n = 64'((2 * k - 1) * 20 + 561);
      lhs = 264'd1;
      rhs = 264'd1;
      for (int i = 0; i < 5; i++) begin
         lhs = lhs * 264'(q);
         rhs = rhs << 16;
      end
      for (int i = 0; i < 12; i++) begin
         lhs = lhs * 264'd10761;
         rhs = rhs * 264'(n);
      end
      return lhs >= rhs;
   endfunction

   // smallest q0.16 value reaching each gray level
   function automatic srgb_tab_type srgb_thresholds();
      srgb_tab_type tab;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      tab = '0;
      for (int k = 1; k < 256; k++) begin
         lo = 0;
         hi = 65537;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (srgb_meets(mid, k)) begin
               hi = mid;
            end else begin
               lo = mid + 1;
            end
         end
         tab[k] = SRGB_W'(lo);
      end
      return tab;
   endfunction

   localparam srgb_tab_type SRGB_THRESH = srgb_thresholds();

endpackage

FILE: hdl/xyz_to_srgb_pixel_encoder.sv
// XYZ to 8-bit RGB pixel encoder.
// request channel: req_valid with req_x_value, req_y_value, req_z_value (unsigned
//   q2.14); a request is taken at a clock edge where req_valid is high and
//   req_stall is low.
// response channel: rsp_valid with the three codes and rsp_was_scaled; a
//   response is taken where rsp_valid is high and rsp_stall is low.
// csr channel: csr_valid with csr_encode_mode (0 srgb, 1 linear); csr_ready is
//   always high. change the mode only while no pixel is in flight.
// throughput: one pixel per clock while rsp_stall does not hold the pipeline.
//   the pipeline is made of the matrix stages, one divider stage per quotient
//   bit, and the eight-step srgb threshold search.
// when rsp_stall is high with a response waiting, the whole pipeline holds
//   and req_stall rises; nothing is dropped or repeated.
// reset clears all valid bits and sets the mode to srgb.
module xyz_to_srgb_pixel_encoder #(
   parameter int LINEAR_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [15:0] req_x_value,
   input  logic [15:0] req_y_value,
   input  logic [15:0] req_z_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_red_code,
   output logic [7:0] rsp_green_code,
   output logic [7:0] rsp_blue_code,
   output logic rsp_was_scaled,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_encode_mode
);

   localparam int QB = (LINEAR_FRAC_BITS > xyz2s_pkg::SRGB_BITS) ?
                       LINEAR_FRAC_BITS : xyz2s_pkg::SRGB_BITS;

   logic adv;
   logic mode_ff;
   logic mode_in;
   xyz2s_pkg::stage_ctl_type mat_ctl;
   logic [xyz2s_pkg::CHAN_W-1:0] mat_chan [3];
   logic [xyz2s_pkg::CHAN_W-1:0] mat_max;
   xyz2s_pkg::stage_ctl_type div_ctl;
   logic [xyz2s_pkg::CHAN_W-1:0] div_chan [3];
   logic [QB:0] div_quo [3];
   logic [7:0] codes [3];

   // pipeline moves unless a waiting response is stalled
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // mode register
   assign mode_in = (csr_valid && csr_ready) ? csr_encode_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   xyz2s_matrix u_matrix (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .x_value  (req_x_value),
      .y_value  (req_y_value),
      .z_value  (req_z_value),
      .out_ctl  (mat_ctl),
      .out_chan (mat_chan),
      .out_max  (mat_max)
   );

   xyz2s_divider #(
      .QB (QB)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (mat_ctl),
      .in_chan  (mat_chan),
      .in_max   (mat_max),
      .out_ctl  (div_ctl),
      .out_chan (div_chan),
      .out_quo  (div_quo)
   );

   xyz2s_encoder #(
      .QB (QB),
      .LF (LINEAR_FRAC_BITS)
   ) u_encoder (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .mode       (mode_ff),
      .in_ctl     (div_ctl),
      .in_chan    (div_chan),
      .in_quo     (div_quo),
      .out_valid  (rsp_valid),
      .out_code   (codes),
      .out_scaled (rsp_was_scaled)
   );

   assign rsp_red_code = codes[0];
   assign rsp_green_code = codes[1];
   assign rsp_blue_code = codes[2];

`ifndef SYNTHESIS
   // a csr write lands in the mode register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> mode_ff == $past(csr_encode_mode))
      else $error("mode register did not take csr write");

   // the channel equal to the maximum divides to exactly one
   a_div_unit: assert property (@(posedge clock) disable iff (reset)
      div_ctl.valid && div_ctl.scaled |->
         div_quo[0] == ((QB+1)'(1) << QB) || div_quo[1] == ((QB+1)'(1) << QB) ||
         div_quo[2] == ((QB+1)'(1) << QB))
      else $error("scaled pixel has no channel at full scale");

   // a scaled pixel has a channel at full code
   a_scaled_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_scaled |->
         rsp_red_code == 8'd255 || rsp_green_code == 8'd255 || rsp_blue_code == 8'd255)
      else $error("scaled response without full code");
`endif

endmodule

FILE: hdl/xyz2s_matrix.sv
module xyz2s_matrix (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  logic [15:0] x_value,
   input  logic [15:0] y_value,
   input  logic [15:0] z_value,
   output xyz2s_pkg::stage_ctl_type out_ctl,
   output logic [xyz2s_pkg::CHAN_W-1:0] out_chan [3],
   output logic [xyz2s_pkg::CHAN_W-1:0] out_max
);

   logic [15:0] xyz [3];
   logic signed [xyz2s_pkg::PROD_W-1:0] prod_in [3][3];
   logic signed [xyz2s_pkg::PROD_W-1:0] prod_ff [3][3];
   logic signed [xyz2s_pkg::SUM_W-1:0] sum_in [3];
   logic signed [xyz2s_pkg::SUM_W-1:0] sum_ff [3];
   logic signed [xyz2s_pkg::SUM_W-1:0] mx;
   logic [xyz2s_pkg::CHAN_W-1:0] chan_in [3];
   logic [xyz2s_pkg::CHAN_W-1:0] chan_ff [3];
   logic [xyz2s_pkg::CHAN_W-1:0] max_in;
   logic [xyz2s_pkg::CHAN_W-1:0] max_ff;
   logic scaled_in;
   logic scaled_ff;
   logic v1_ff;
   logic v2_ff;
   logic v3_ff;

   assign xyz[0] = x_value;
   assign xyz[1] = y_value;
   assign xyz[2] = z_value;

   // products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed({1'b0, xyz[j]}) * xyz2s_pkg::MAT_COEF[i][j];
         end
      end
   end

   // row sums
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = xyz2s_pkg::SUM_W'(prod_ff[i][0]) + xyz2s_pkg::SUM_W'(prod_ff[i][1])
                   + xyz2s_pkg::SUM_W'(prod_ff[i][2]);
      end
   end

   // largest channel, clip negatives
   always_comb begin
      mx = sum_ff[0];
      if (sum_ff[1] > mx) begin
         mx = sum_ff[1];
      end
      if (sum_ff[2] > mx) begin
         mx = sum_ff[2];
      end
      scaled_in = mx > (xyz2s_pkg::SUM_W'(1) <<< xyz2s_pkg::ACC_FRAC);
      max_in = (mx > 0) ? mx[xyz2s_pkg::CHAN_W-1:0] : '0;
      for (int i = 0; i < 3; i++) begin
         chan_in[i] = (sum_ff[i] > 0) ? sum_ff[i][xyz2s_pkg::CHAN_W-1:0] : '0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         sum_ff <= sum_in;
         chan_ff <= chan_in;
         max_ff <= max_in;
         scaled_ff <= scaled_in;
      end
   end

   assign out_ctl.valid = v3_ff;
   assign out_ctl.scaled = scaled_ff;
   assign out_chan = chan_ff;
   assign out_max = max_ff;

endmodule

FILE: hdl/xyz2s_divider.sv
module xyz2s_divider #(
   parameter int QB = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  xyz2s_pkg::stage_ctl_type in_ctl,
   input  logic [xyz2s_pkg::CHAN_W-1:0] in_chan [3],
   input  logic [xyz2s_pkg::CHAN_W-1:0] in_max,
   output xyz2s_pkg::stage_ctl_type out_ctl,
   output logic [xyz2s_pkg::CHAN_W-1:0] out_chan [3],
   output logic [QB:0] out_quo [3]
);

   localparam int CW = xyz2s_pkg::CHAN_W;

   logic [CW-1:0] rem_in [QB+1][3];
   logic [CW-1:0] rem_ff [QB+1][3];
   logic [QB:0] quo_in [QB+1][3];
   logic [QB:0] quo_ff [QB+1][3];
   logic [CW-1:0] chan_ff [QB+1][3];
   logic [CW-1:0] max_ff [QB+1];
   xyz2s_pkg::stage_ctl_type ctl_ff [QB+1];

   // one quotient bit per stage, restoring
   always_comb begin
      logic [CW:0] r2;
      logic ge;
      for (int c = 0; c < 3; c++) begin
         ge = in_chan[c] >= in_max;
         rem_in[0][c] = ge ? (in_chan[c] - in_max) : in_chan[c];
         quo_in[0][c] = {{QB{1'b0}}, ge};
      end
      for (int s = 1; s <= QB; s++) begin
         for (int c = 0; c < 3; c++) begin
            r2 = {rem_ff[s-1][c], 1'b0};
            ge = r2 >= {1'b0, max_ff[s-1]};
            rem_in[s][c] = ge ? CW'(r2 - {1'b0, max_ff[s-1]}) : r2[CW-1:0];
            quo_in[s][c] = {quo_ff[s-1][c][QB-1:0], ge};
         end
      end
   end

   // valid and control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QB; s++) begin
            ctl_ff[s].valid <= 1'b0;
         end
      end else if (adv) begin
         ctl_ff[0] <= in_ctl;
         for (int s = 1; s <= QB; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         chan_ff[0] <= in_chan;
         max_ff[0] <= in_max;
         for (int s = 1; s <= QB; s++) begin
            chan_ff[s] <= chan_ff[s-1];
            max_ff[s] <= max_ff[s-1];
         end
      end
   end

   assign out_ctl = ctl_ff[QB];
   assign out_chan = chan_ff[QB];
   assign out_quo = quo_ff[QB];

endmodule

FILE: hdl/xyz2s_encoder.sv
module xyz2s_encoder #(
   parameter int QB = 16,
   parameter int LF = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic mode,
   input  xyz2s_pkg::stage_ctl_type in_ctl,
   input  logic [xyz2s_pkg::CHAN_W-1:0] in_chan [3],
   input  logic [QB:0] in_quo [3],
   output logic out_valid,
   output logic [7:0] out_code [3],
   output logic out_scaled
);

   localparam int LW = LF + 1;
   localparam int PW = LF + 9;
   localparam int SW = xyz2s_pkg::SRGB_W;

   logic [SW-1:0] q16;
   logic [LW-1:0] lin;
   logic [PW-1:0] lsum;
   logic [SW-1:0] q_in [3];
   logic [7:0] lcode_in [3];
   logic [SW-1:0] q_ff [9][3];
   logic [7:0] lcode_ff [9][3];
   logic [7:0] code_in [9][3];
   logic [7:0] code_ff [9][3];
   xyz2s_pkg::stage_ctl_type ctl_ff [9];
   logic [7:0] rsp_code_in [3];
   logic [7:0] rsp_code_ff [3];
   logic rsp_scaled_ff;
   logic rsp_valid_ff;

   // linear values and linear code
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (in_ctl.scaled) begin
            q16 = SW'(in_quo[c] >> (QB - xyz2s_pkg::SRGB_BITS));
            lin = LW'(in_quo[c] >> (QB - LF));
         end else begin
            q16 = SW'(in_chan[c] >> (xyz2s_pkg::ACC_FRAC - xyz2s_pkg::SRGB_BITS));
            lin = LW'(in_chan[c] >> (xyz2s_pkg::ACC_FRAC - LF));
         end
         lsum = {lin, 8'b0} - PW'(lin) + (PW'(1) << (LF - 1));
         q_in[c] = q16;
         lcode_in[c] = lsum[LF+7:LF];
      end
   end

   // srgb gray level by binary search over thresholds, one bit a stage
   always_comb begin
      logic [7:0] cand;
      for (int c = 0; c < 3; c++) begin
         code_in[0][c] = '0;
      end
      for (int s = 1; s <= 8; s++) begin
         for (int c = 0; c < 3; c++) begin
            cand = code_ff[s-1][c] | (8'd1 << (8 - s));
            code_in[s][c] = (q_ff[s-1][c] >= xyz2s_pkg::SRGB_THRESH[cand]) ?
                            cand : code_ff[s-1][c];
         end
      end
   end

   // mode select
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rsp_code_in[c] = mode ? lcode_ff[8][c] : code_ff[8][c];
      end
   end

   // valid and control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= 8; s++) begin
            ctl_ff[s].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         ctl_ff[0] <= in_ctl;
         for (int s = 1; s <= 8; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
         rsp_valid_ff <= ctl_ff[8].valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff[0] <= q_in;
         lcode_ff[0] <= lcode_in;
         code_ff[0] <= code_in[0];
         for (int s = 1; s <= 8; s++) begin
            q_ff[s] <= q_ff[s-1];
            lcode_ff[s] <= lcode_ff[s-1];
            code_ff[s] <= code_in[s];
         end
         rsp_code_ff <= rsp_code_in;
         rsp_scaled_ff <= ctl_ff[8].scaled;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_code = rsp_code_ff;
   assign out_scaled = rsp_scaled_ff;

endmodule
